[sv/aws_pkg.sv]
// shared types and constants for the angle window speed estimator
// no dependencies; compiled before every other file of the block

package aws_pkg;

    // register indexes of the configuration port
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_STEP = 2'd1;

    localparam int CFG_DATA_W = 16;
    localparam int ANGLE_W    = 16;
    localparam int SPEED_W    = 32;
    localparam int PERIOD_W   = 16;
    localparam int MAX_STEP_W = 15;

    localparam logic [PERIOD_W-1:0]   PERIOD_RESET   = 16'd5000;
    localparam logic [MAX_STEP_W-1:0] MAX_STEP_RESET = 15'd10430;

    // microseconds per second
    localparam int SCALE_W = 20;
    localparam logic [SCALE_W-1:0] SCALE = 20'd1000000;

    localparam logic [SPEED_W-1:0] SPEED_MAX = 32'h7FFF_FFFF;
    localparam logic [SPEED_W-1:0] SPEED_MIN = 32'h8000_0000;

    // status of the serial divider
    typedef struct packed {
        logic               done;
        logic               ovf;
        logic [SPEED_W-1:0] quot;
    } aws_div_res_t;

endpackage

[sv/aws_if.sv]
// valid/ready channel interfaces for angle samples and speed results
// no dependencies

interface aws_angle_if;
    logic        valid;
    logic        ready;
    logic [15:0] angle;

    modport source (output valid, output angle, input ready);
    modport sink   (input valid, input angle, output ready);
endinterface

interface aws_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] speed;
    logic               window_full;
    logic               sample_rejected;

    modport source (output valid, output speed, output window_full,
                    output sample_rejected, input ready);
    modport sink   (input valid, input speed, input window_full,
                    input sample_rejected, output ready);
endinterface

[sv/angle_window_speed_estimator.sv]
// top level of the angle window speed estimator: control sequencer, state
// registers and output register; uses aws_pkg, aws_if, aws_ring_mem, aws_divider

// Takes one 16-bit angle beat (65536 counts per turn) at a time and returns one
// result beat per sample: the mean speed in counts per second over the last
// WINDOW_DEPTH accepted steps, a window-full flag and a rejected flag. The first
// sample after reset only sets the base angle. A wrapped step larger than
// max_step in magnitude is dropped and flagged. Steps are held in a synchronous
// ring memory; an entry not yet written since reset reads as zero by way of the
// fill count, so no clearing pass is needed. Each sample takes a memory
// read, a read-modify-write of the running sum, one multiply stage, and a
// restoring serial divider that makes one quotient bit per cycle over
// (|sum| * 1e6) / (fill * period); the divider is skipped while the ring is
// empty. A new sample is taken as soon as the previous result sits in the
// output register, even if that result has not been taken yet. Configuration
// writes are meant for when no sample is in flight.

module angle_window_speed_estimator #(
    parameter int WINDOW_DEPTH = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    aws_angle_if.sink                          samples,
    aws_result_if.source                       results,
    input  logic                               cfg_we,
    input  logic [aws_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [aws_pkg::CFG_DATA_W-1:0]     cfg_data
);

    import aws_pkg::*;

    // derived widths
    localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W  = ANGLE_W + $clog2(WINDOW_DEPTH);
    localparam int MAG_W  = SUM_W - 1;
    localparam int NUM_W  = MAG_W + SCALE_W;
    localparam int DEN_W  = CNT_W + PERIOD_W;

    // one-hot sequencer states
    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_UPD  = 5'b00010,
        ST_MUL  = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [PERIOD_W-1:0]   period_reg;
    logic [MAX_STEP_W-1:0] max_step_reg;

    // estimator state
    logic [ANGLE_W-1:0]      angle_reg;
    logic [ANGLE_W-1:0]      base_reg, base_next;
    logic                    have_base_reg, have_base_next;
    logic [SLOT_W-1:0]       slot_reg, slot_next;
    logic [CNT_W-1:0]        fill_reg, fill_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic                    rej_reg, rej_next;
    logic                    neg_reg;
    logic                    empty_reg;

    // output register
    logic                    out_valid_reg, out_valid_next;
    logic [SPEED_W-1:0]      speed_reg;
    logic                    full_reg;
    logic                    rej_out_reg;

    // ring memory and divider hookup
    logic                    mem_we;
    logic [ANGLE_W-1:0]      mem_rdata;
    logic                    div_start;
    logic [NUM_W-1:0]        div_num;
    logic [DEN_W-1:0]        div_den;
    aws_div_res_t            div_res;

    // step and magnitude of the current sample
    logic signed [ANGLE_W-1:0] diff;
    logic [ANGLE_W:0]          diff_mag;
    logic                      too_big;
    logic signed [SUM_W-1:0]   old_step;
    logic [SUM_W-1:0]          sum_abs;
    logic [PERIOD_W-1:0]       period_eff;
    logic [SPEED_W-1:0]        speed_calc;
    logic                      in_accept;
    logic                      out_free;

    assign in_accept = samples.valid && samples.ready;
    assign out_free  = !out_valid_reg || results.ready;

    aws_ring_mem #(
        .DEPTH  (WINDOW_DEPTH),
        .ADDR_W (SLOT_W)
    ) u_ring (
        .clk   (clk),
        .we    (mem_we),
        .waddr (slot_reg),
        .wdata (diff),
        .re    (in_accept),
        .raddr (slot_reg),
        .rdata (mem_rdata)
    );

    aws_divider #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .res   (div_res)
    );

    // configuration writes; other indexes are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg   <= PERIOD_RESET;
            max_step_reg <= MAX_STEP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PERIOD:   period_reg   <= cfg_data[PERIOD_W-1:0];
                REG_MAX_STEP: max_step_reg <= cfg_data[MAX_STEP_W-1:0];
                default:      ;
            endcase
        end
    end

    // wrapped step against the base and its magnitude (half turn gives 32768)
    always_comb
    begin
        diff     = signed'(angle_reg - base_reg);
        diff_mag = diff[ANGLE_W-1] ? ({1'b0, ~diff} + (ANGLE_W+1)'(1)) : {1'b0, diff};
        too_big  = diff_mag > (ANGLE_W+1)'(max_step_reg);
        // slots not yet written since reset count as zero
        old_step = (fill_reg < CNT_W'(WINDOW_DEPTH)) ? '0
                                                      : SUM_W'(signed'(mem_rdata));
    end

    // multiply stage operands feed the divider load registers directly
    always_comb
    begin
        sum_abs    = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
        period_eff = (period_reg == '0) ? PERIOD_W'(1) : period_reg;
        div_num    = NUM_W'(sum_abs[MAG_W-1:0]) * NUM_W'(SCALE);
        div_den    = DEN_W'(fill_reg) * DEN_W'(period_eff);
    end

    // sign and saturation of the quotient, zero for an empty window
    always_comb
    begin
        if (empty_reg)
        begin
            speed_calc = '0;
        end
        else if (neg_reg)
        begin
            if (div_res.ovf || div_res.quot[SPEED_W-1])
            begin
                speed_calc = SPEED_MIN;
            end
            else
            begin
                speed_calc = SPEED_W'(0) - div_res.quot;
            end
        end
        else if (div_res.ovf || div_res.quot[SPEED_W-1])
        begin
            speed_calc = SPEED_MAX;
        end
        else
        begin
            speed_calc = div_res.quot;
        end
    end

    // sequencer: read slot, update ring and sum, multiply, divide, hand over
    always_comb
    begin
        state_next     = state_reg;
        base_next      = base_reg;
        have_base_next = have_base_reg;
        slot_next      = slot_reg;
        fill_next      = fill_reg;
        sum_next       = sum_reg;
        rej_next       = rej_reg;
        out_valid_next = out_valid_reg;
        mem_we         = 1'b0;
        div_start      = 1'b0;

        if (results.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (samples.valid)
                begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                // ring read data for the write slot is valid here
                rej_next = 1'b0;
                if (!have_base_reg)
                begin
                    base_next      = angle_reg;
                    have_base_next = 1'b1;
                end
                else if (too_big)
                begin
                    rej_next = 1'b1;
                end
                else
                begin
                    mem_we    = 1'b1;
                    sum_next  = sum_reg + SUM_W'(diff) - old_step;
                    base_next = angle_reg;
                    slot_next = (slot_reg == SLOT_W'(WINDOW_DEPTH - 1)) ? '0
                                                                         : slot_reg + SLOT_W'(1);
                    if (fill_reg < CNT_W'(WINDOW_DEPTH))
                    begin
                        fill_next = fill_reg + CNT_W'(1);
                    end
                end
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if (fill_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_res.done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            base_reg      <= '0;
            have_base_reg <= 1'b0;
            slot_reg      <= '0;
            fill_reg      <= '0;
            sum_reg       <= '0;
            rej_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            base_reg      <= base_next;
            have_base_reg <= have_base_next;
            slot_reg      <= slot_next;
            fill_reg      <= fill_next;
            sum_reg       <= sum_next;
            rej_reg       <= rej_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            angle_reg <= samples.angle;
        end
        if (state_reg == ST_MUL)
        begin
            neg_reg   <= sum_reg[SUM_W-1];
            empty_reg <= (fill_reg == '0);
        end
        if ((state_reg == ST_DONE) && out_free)
        begin
            speed_reg   <= speed_calc;
            full_reg    <= (fill_reg == CNT_W'(WINDOW_DEPTH));
            rej_out_reg <= rej_reg;
        end
    end

    assign samples.ready           = (state_reg == ST_IDLE);
    assign results.valid           = out_valid_reg;
    assign results.speed           = signed'(speed_reg);
    assign results.window_full     = full_reg;
    assign results.sample_rejected = rej_out_reg;

endmodule

[sv/aws_ring_mem.sv]
// ring of accepted angle steps: one write port, one read port, registered read
// no dependencies

module aws_ring_mem #(
    parameter int DEPTH  = 8,
    parameter int ADDR_W = 3
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [15:0]       wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [15:0]       rdata
);

    logic [15:0] mem [DEPTH];
    logic [15:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[sv/aws_divider.sv]
// restoring serial divider, one quotient bit per cycle, keeps low 32 bits
// plus a sticky overflow flag; depends on aws_pkg

module aws_divider #(
    parameter int NUM_W = 38,
    parameter int DEN_W = 20
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [NUM_W-1:0]     num,
    input  logic [DEN_W-1:0]     den,
    output aws_pkg::aws_div_res_t res
);

    import aws_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0]   num_reg;
    logic [DEN_W-1:0]   den_reg;
    logic [DEN_W-1:0]   rem_reg;
    logic [SPEED_W-1:0] quot_reg;
    logic               ovf_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;

    logic [DEN_W:0]     rem_sh;
    logic [DEN_W:0]     rem_sub;
    logic               ge;

    always_comb
    begin
        rem_sh  = {rem_reg, num_reg[NUM_W-1]};
        ge      = rem_sh >= {1'b0, den_reg};
        rem_sub = rem_sh - {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg  <= num;
            den_reg  <= den;
            rem_reg  <= '0;
            quot_reg <= '0;
            ovf_reg  <= 1'b0;
        end
        else if (busy_reg)
        begin
            num_reg  <= num_reg << 1;
            rem_reg  <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            quot_reg <= {quot_reg[SPEED_W-2:0], ge};
            ovf_reg  <= ovf_reg | quot_reg[SPEED_W-1];
        end
    end

    assign res.done = done_reg;
    assign res.ovf  = ovf_reg;
    assign res.quot = quot_reg;

endmodule
